// ===== hw/rtl/scrc_pkg.sv =====
// Shared types, codes and helper functions for the shadow cell race checker.
// Used by every module under hw/rtl; depends on nothing else.
package scrc_pkg;

	localparam int CELLS       = 4;
	localparam int SLOT_W      = 2;
	localparam int GRAN_W      = 10;
	localparam int TID_W       = 4;
	localparam int IN_EPOCH_W  = 32;
	localparam int MASK_W      = 8;
	localparam int ADDR_W      = GRAN_W + SLOT_W;
	localparam int CLK_ADDR_W  = 2 * TID_W;
	localparam int MAX_REPORTS = 4;
	localparam int REP_W       = 3;
	localparam int WIDTH_W     = 4;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int S_TDATA_W   = 96;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 56;
	localparam int M_TUSER_W   = 1;

	localparam logic [MASK_W-1:0]  FULL_MASK = 8'hff;
	localparam logic [WIDTH_W-1:0] NO_WIDTH  = 4'd9;

	// item kinds on the input side
	localparam logic [1:0] OP_ACCESS    = 2'd0;
	localparam logic [1:0] OP_SET_CLOCK = 2'd1;
	localparam logic [1:0] OP_CLEAR     = 2'd2;

	// result kinds
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_DONE   = 1'b1;

	// store actions reported on completion
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_OWN       = 3'd1;
	localparam logic [2:0] ACT_FREE      = 3'd2;
	localparam logic [2:0] ACT_EVICT     = 3'd3;
	localparam logic [2:0] ACT_REDUNDANT = 3'd4;

	// register word index (paddr[2])
	localparam logic REG_ENABLE = 1'b0;

	typedef struct packed {
		logic              valid;
		logic [TID_W-1:0]  tid;
		logic [MASK_W-1:0] mask;
		logic              wr;
		logic              at;
	} cell_meta_t;

	localparam int META_W = $bits(cell_meta_t);

	typedef struct packed {
		logic               free;
		logic               own_fit;
		logic               same;
		logic               race_cand;
		logic               newer;
		logic               beats;
		logic [WIDTH_W-1:0] width;
	} eval_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [GRAN_W-1:0]     granule;
		logic [2:0]            byte_offset;
		logic [3:0]            access_size;
		logic                  write_flag;
		logic                  atomic_flag;
		logic [TID_W-1:0]      thread_id;
		logic [IN_EPOCH_W-1:0] thread_epoch;
		logic [TID_W-1:0]      clock_peer;
		logic [IN_EPOCH_W-1:0] clock_value;
	} in_item_t;

	typedef struct packed {
		logic                  kind;
		logic [TID_W-1:0]      peer_tid;
		logic [IN_EPOCH_W-1:0] peer_epoch;
		logic                  peer_write;
		logic                  peer_atomic;
		logic [MASK_W-1:0]     peer_mask;
		logic [SLOT_W-1:0]     slot_used;
		logic [2:0]            store_action;
		logic                  last;
	} result_t;

	// input tdata layout, highest field first
	typedef struct packed {
		logic [4:0]            pad;
		logic [IN_EPOCH_W-1:0] clock_value;
		logic [TID_W-1:0]      clock_peer;
		logic [IN_EPOCH_W-1:0] thread_epoch;
		logic [TID_W-1:0]      thread_id;
		logic                  atomic_flag;
		logic                  write_flag;
		logic [3:0]            access_size;
		logic [2:0]            byte_offset;
		logic [GRAN_W-1:0]     granule;
	} s_tdata_t;

	// output tdata layout, highest field first
	typedef struct packed {
		logic [4:0]            pad;
		logic [2:0]            store_action;
		logic [SLOT_W-1:0]     slot_used;
		logic [MASK_W-1:0]     peer_mask;
		logic                  peer_atomic;
		logic                  peer_write;
		logic [IN_EPOCH_W-1:0] peer_epoch;
		logic [TID_W-1:0]      peer_tid;
	} m_tdata_t;

	// byte mask of an access inside its 8-byte granule
	function automatic logic [MASK_W-1:0] mask_of(input logic [2:0] off, input logic [3:0] size);
		logic [4:0]        reach;
		logic [MASK_W-1:0] ones;
		reach = 5'(off) + 5'(size);
		ones  = MASK_W'((9'd1 << size) - 9'd1);
		if (size >= 4'd8 || reach > 5'd8) begin
			mask_of = FULL_MASK;
		end else begin
			mask_of = ones << off;
		end
	endfunction

	function automatic logic [WIDTH_W-1:0] popcount8(input logic [MASK_W-1:0] m);
		logic [WIDTH_W-1:0] n;
		n = '0;
		for (int i = 0; i < MASK_W; i++) begin
			n = n + WIDTH_W'(m[i]);
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/scrc_cell_unit.sv =====
// Shared compare unit: judges one shadow cell against the current access.
// Reused for every slot of a granule by the sequencer; depends on scrc_pkg.
module scrc_cell_unit import scrc_pkg::*; #(
	parameter int EPOCH_BITS = 32
) (
	input  cell_meta_t             probe,
	input  logic [EPOCH_BITS-1:0]  cell_epoch,
	input  cell_meta_t             mine,
	input  logic [EPOCH_BITS-1:0]  mine_epoch,
	input  logic [EPOCH_BITS-1:0]  clk_epoch,
	input  logic [WIDTH_W-1:0]     best_w,
	input  logic [EPOCH_BITS-1:0]  best_e,
	output eval_t                  ev
);

	logic               own;
	logic [WIDTH_W-1:0] w;

	assign own = probe.valid && (probe.tid == mine.tid);
	assign w   = popcount8(probe.mask);

	always_comb begin
		ev.free    = !probe.valid;
		// own cell that the new access covers and is at least as strong as
		ev.own_fit = own && ((probe.mask & ~mine.mask) == '0) && (mine.wr || !probe.wr);
		ev.same    = (cell_epoch == mine_epoch) && (probe.mask == mine.mask)
			&& (probe.wr == mine.wr) && (probe.at == mine.at);
		ev.race_cand = probe.valid && !own && ((probe.mask & mine.mask) != '0)
			&& (mine.wr || probe.wr) && !(mine.at && probe.at);
		ev.newer   = cell_epoch > clk_epoch;
		ev.beats   = (w < best_w) || ((w == best_w) && (cell_epoch < best_e));
		ev.width   = w;
	end

endmodule

// ===== hw/rtl/scrc_seq.sv =====
// Sequencer for the race checker: shadow and clock memories, per-slot scan,
// victim choice and the output register. Depends on scrc_pkg, scrc_cell_unit.
module scrc_seq import scrc_pkg::*; #(
	parameter int EPOCH_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     enable,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  out_item
);

	localparam int CELL_W    = META_W + EPOCH_BITS;
	localparam int DEPTH     = 1 << ADDR_W;
	localparam int CLK_DEPTH = 1 << CLK_ADDR_W;

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CLKSET = 4'd2;
	localparam logic [3:0] S_CLEAR  = 4'd3;
	localparam logic [3:0] S_RD     = 4'd4;
	localparam logic [3:0] S_EV     = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_REP    = 4'd7;
	localparam logic [3:0] S_STORE  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [SLOT_W-1:0] slot_q;
	logic [REP_W-1:0]  nrep_q;
	logic              free_found_q;
	logic              own_found_q;
	logic              redundant_q;
	logic              out_valid_q;

	logic [GRAN_W-1:0]     gran_q;
	logic [TID_W-1:0]      tid_q;
	logic [TID_W-1:0]      peer_q;
	logic [EPOCH_BITS-1:0] cval_q;
	cell_meta_t            mine_q;
	logic [EPOCH_BITS-1:0] mine_epoch_q;
	logic [SLOT_W-1:0]     vacant_slot_q;
	logic [SLOT_W-1:0]     match_slot_q;
	logic [WIDTH_W-1:0]    best_w_q;
	logic [EPOCH_BITS-1:0] best_e_q;
	logic [SLOT_W-1:0]     best_slot_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic [2:0]            res_act_q;
	result_t               out_q;

	logic [CELL_W-1:0]     shadow_mem [DEPTH];
	logic [CELL_W-1:0]     sh_rdata_q;
	logic [EPOCH_BITS-1:0] ck_mem [CLK_DEPTH];
	logic [EPOCH_BITS-1:0] ck_rdata_q;

	logic                  sh_we;
	logic [ADDR_W-1:0]     sh_waddr;
	logic [CELL_W-1:0]     sh_wdata;
	logic                  sh_re;
	logic                  ck_we;
	logic [CLK_ADDR_W-1:0] ck_waddr;
	logic [EPOCH_BITS-1:0] ck_wdata;
	logic                  ck_re;
	logic [CLK_ADDR_W-1:0] ck_raddr;

	cell_meta_t            rd_meta;
	logic [EPOCH_BITS-1:0] rd_epoch;
	eval_t                 ev;
	logic                  last_slot;
	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	result_t               out_next;
	logic [SLOT_W-1:0]     st_slot;
	logic [2:0]            st_act;

	assign rd_meta   = sh_rdata_q[CELL_W-1 -: META_W];
	assign rd_epoch  = sh_rdata_q[EPOCH_BITS-1:0];
	assign last_slot = (slot_q == SLOT_W'(CELLS - 1));
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && (state_q == S_REP || state_q == S_DONE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	scrc_cell_unit #(.EPOCH_BITS(EPOCH_BITS)) u_unit (
		.probe      (rd_meta),
		.cell_epoch (rd_epoch),
		.mine       (mine_q),
		.mine_epoch (mine_epoch_q),
		.clk_epoch  (ck_rdata_q),
		.best_w     (best_w_q),
		.best_e     (best_e_q),
		.ev         (ev)
	);

	// where the access gets recorded
	always_comb begin
		if (redundant_q) begin
			st_slot = match_slot_q;
			st_act  = ACT_REDUNDANT;
		end else if (own_found_q) begin
			st_slot = match_slot_q;
			st_act  = ACT_OWN;
		end else if (free_found_q) begin
			st_slot = vacant_slot_q;
			st_act  = ACT_FREE;
		end else begin
			st_slot = best_slot_q;
			st_act  = ACT_EVICT;
		end
	end

	always_comb begin
		sh_we    = 1'b0;
		sh_waddr = {gran_q, slot_q};
		sh_wdata = '0;
		ck_we    = 1'b0;
		ck_waddr = {tid_q, peer_q};
		ck_wdata = cval_q;
		unique case (state_q)
			S_INIT: begin
				sh_we    = 1'b1;
				sh_waddr = sweep_q;
				ck_we    = 1'b1;
				ck_waddr = sweep_q[CLK_ADDR_W-1:0];
				ck_wdata = '0;
			end
			S_CLEAR: begin
				sh_we = 1'b1;
			end
			S_CLKSET: begin
				ck_we = 1'b1;
			end
			S_STORE: begin
				sh_we    = !redundant_q;
				sh_waddr = {gran_q, st_slot};
				sh_wdata = {mine_q, mine_epoch_q};
			end
			default: begin
				sh_we = 1'b0;
			end
		endcase
	end

	assign sh_re    = (state_q == S_RD);
	assign ck_re    = (state_q == S_EV) && ev.race_cand;
	assign ck_raddr = {tid_q, rd_meta.tid};

	always_ff @(posedge clk) begin
		if (sh_we) begin
			shadow_mem[sh_waddr] <= sh_wdata;
		end
		if (sh_re) begin
			sh_rdata_q <= shadow_mem[{gran_q, slot_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (ck_we) begin
			ck_mem[ck_waddr] <= ck_wdata;
		end
		if (ck_re) begin
			ck_rdata_q <= ck_mem[ck_raddr];
		end
	end

	always_comb begin
		out_next = '0;
		if (state_q == S_REP) begin
			out_next.kind        = KIND_REPORT;
			out_next.peer_tid    = rd_meta.tid;
			out_next.peer_epoch  = IN_EPOCH_W'(rd_epoch);
			out_next.peer_write  = rd_meta.wr;
			out_next.peer_atomic = rd_meta.at;
			out_next.peer_mask   = rd_meta.mask;
		end else begin
			out_next.kind         = KIND_DONE;
			out_next.slot_used    = res_slot_q;
			out_next.store_action = res_act_q;
			out_next.last         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			sweep_q      <= '0;
			slot_q       <= '0;
			nrep_q       <= '0;
			free_found_q <= 1'b0;
			own_found_q  <= 1'b0;
			redundant_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						slot_q       <= '0;
						nrep_q       <= '0;
						free_found_q <= 1'b0;
						own_found_q  <= 1'b0;
						redundant_q  <= 1'b0;
						unique case (in_item.op)
							OP_ACCESS:    state_q <= enable ? S_RD : S_DONE;
							OP_SET_CLOCK: state_q <= S_CLKSET;
							OP_CLEAR:     state_q <= S_CLEAR;
							default:      state_q <= S_DONE;
						endcase
					end
				end
				S_CLKSET: begin
					state_q <= S_DONE;
				end
				S_CLEAR: begin
					slot_q <= slot_q + 1'b1;
					if (last_slot) begin
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (ev.free) begin
						free_found_q <= 1'b1;
					end else if (ev.own_fit && !own_found_q) begin
						own_found_q <= 1'b1;
						redundant_q <= ev.same;
					end
					if (ev.race_cand) begin
						state_q <= S_CMP;
					end else if (last_slot) begin
						state_q <= S_STORE;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_CMP: begin
					if (ev.newer && nrep_q < REP_W'(MAX_REPORTS)) begin
						state_q <= S_REP;
					end else if (last_slot) begin
						state_q <= S_STORE;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_REP: begin
					if (out_free) begin
						nrep_q <= nrep_q + 1'b1;
						if (last_slot) begin
							state_q <= S_STORE;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_STORE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gran_q       <= in_item.granule;
			tid_q        <= in_item.thread_id;
			peer_q       <= in_item.clock_peer;
			cval_q       <= EPOCH_BITS'(in_item.clock_value);
			mine_q.valid <= 1'b1;
			mine_q.tid   <= in_item.thread_id;
			mine_q.mask  <= mask_of(in_item.byte_offset, in_item.access_size);
			mine_q.wr    <= in_item.write_flag;
			mine_q.at    <= in_item.atomic_flag;
			mine_epoch_q <= EPOCH_BITS'(in_item.thread_epoch);
			best_w_q     <= NO_WIDTH;
			best_e_q     <= '1;
			best_slot_q  <= '0;
			res_slot_q   <= '0;
			res_act_q    <= ACT_NONE;
		end
		if (state_q == S_EV) begin
			if (ev.free && !free_found_q) begin
				vacant_slot_q <= slot_q;
			end
			if (!ev.free && ev.own_fit && !own_found_q) begin
				match_slot_q <= slot_q;
			end
			// narrowest, then oldest cell is the eviction victim
			if (ev.beats) begin
				best_w_q    <= ev.width;
				best_e_q    <= rd_epoch;
				best_slot_q <= slot_q;
			end
		end
		if (state_q == S_STORE) begin
			res_slot_q <= st_slot;
			res_act_q  <= st_act;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

endmodule

// ===== hw/rtl/scrc_regs.sv =====
// APB-style configuration register block: holds the checking enable bit.
// Depends on scrc_pkg for the register index and port widths.
module scrc_regs import scrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic               enable
);

	logic enable_q;
	logic wr_en;
	logic word;

	assign pready = 1'b1;
	assign word   = paddr[PADDR_W-1];
	assign wr_en  = psel && penable && pwrite && pready;
	assign enable = enable_q;
	assign prdata = (word == REG_ENABLE) ? PDATA_W'(enable_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (wr_en && word == REG_ENABLE) begin
			enable_q <= pwdata[0];
		end
	end

endmodule

// ===== hw/rtl/shadow_cell_race_check_top.sv =====
// Shadow cell race checker, top level: stream ports, register port, sequencer.
// Depends on scrc_pkg, scrc_regs, scrc_seq.
//
// Items enter on the s_axis group (op in tuser, operands in tdata). Each item
// yields zero to four race reports (tuser 0) followed by one completion
// (tuser 1, tlast 1) on the m_axis group. One item is worked on at a time:
// s_axis_tready is high only while the sequencer is idle.
// The shadow memory has a single read port and is walked one cell at a time:
// an access reads and judges each cell, looks up the clock for each foreign
// overlapping cell, issues any report, then stores; set_clock writes a clock
// entry, clear wipes the granule, a disabled or unknown item just completes.
// Results wait in an output register; while m_axis_tready is low the
// sequencer holds at the next result and takes no new item.
// After reset the block sweeps the shadow and clock memories to zero with
// s_axis_tready low; register writes are taken meanwhile.
module shadow_cell_race_check_top import scrc_pkg::*; #(
	parameter int EPOCH_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// granule, byte_offset, access_size, write_flag, atomic_flag, thread_id,
	// thread_epoch, clock_peer, clock_value, zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// op
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// peer_tid, peer_epoch, peer_write, peer_atomic, peer_mask, slot_used,
	// store_action, zero pad
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// kind
	output logic [M_TUSER_W-1:0] m_axis_tuser,
	output logic                 m_axis_tlast,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	logic     enable;
	s_tdata_t sd;
	in_item_t item;
	result_t  res;
	m_tdata_t md;

	assign sd = s_axis_tdata;

	always_comb begin
		item.op           = s_axis_tuser;
		item.granule      = sd.granule;
		item.byte_offset  = sd.byte_offset;
		item.access_size  = sd.access_size;
		item.write_flag   = sd.write_flag;
		item.atomic_flag  = sd.atomic_flag;
		item.thread_id    = sd.thread_id;
		item.thread_epoch = sd.thread_epoch;
		item.clock_peer   = sd.clock_peer;
		item.clock_value  = sd.clock_value;
	end

	scrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.enable  (enable)
	);

	scrc_seq #(.EPOCH_BITS(EPOCH_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (res)
	);

	always_comb begin
		md              = '0;
		md.peer_tid     = res.peer_tid;
		md.peer_epoch   = res.peer_epoch;
		md.peer_write   = res.peer_write;
		md.peer_atomic  = res.peer_atomic;
		md.peer_mask    = res.peer_mask;
		md.slot_used    = res.slot_used;
		md.store_action = res.store_action;
	end

	assign m_axis_tdata = md;
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

// ===== hw/rtl/scrc_checker.sv =====
// Port-level checks for the shadow cell race checker, bound to the top level.
// Depends on scrc_pkg and shadow_cell_race_check_top.
module scrc_checker import scrc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic [M_TUSER_W-1:0] m_axis_tuser,
	input logic                 m_axis_tlast
);

	m_tdata_t md;

	assign md = m_axis_tdata;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// only the completion closes an item
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[0] == KIND_DONE)))
		else $error("tlast does not match result kind");

	// reports carry no slot and no store action
	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] == KIND_REPORT
			|-> md.slot_used == '0 && md.store_action == ACT_NONE)
		else $error("report with slot or action set");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item taken while previous item in work");

endmodule

bind shadow_cell_race_check_top scrc_checker u_scrc_checker (.*);
